// ===== rtl/fbfd_pkg.sv =====
package fbfd_pkg;

    // Screen geometry and derived widths
    localparam int SCREEN_WIDTH  = 160;
    localparam int SCREEN_HEIGHT = 80;
    localparam int PIX_COUNT     = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int COL_W         = $clog2(SCREEN_WIDTH);
    localparam int ROW_W         = $clog2(SCREEN_HEIGHT);
    localparam int ADDR_W        = $clog2(PIX_COUNT);
    localparam int PIX_W         = 16;
    localparam int FIELD_W       = 16;
    // Wide enough for x + w - 1 + 1 with two 16-bit signed operands
    localparam int COORD_W       = 20;

    // Widths of the reported box fields
    localparam int OUT_COL_W     = 8;
    localparam int OUT_ROW_W     = 7;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic [COL_W-1:0]          col_t;
    typedef logic [ROW_W-1:0]          row_t;
    typedef logic [ADDR_W-1:0]         addr_t;
    typedef logic [PIX_W-1:0]          pix_t;

    // Command codes
    typedef enum logic [2:0] {
        MODE_PIXEL      = 3'd0,
        MODE_FILL       = 3'd1,
        MODE_OUTLINE    = 3'd2,
        MODE_CLEAR      = 3'd3,
        MODE_INVALIDATE = 3'd4,
        MODE_TAKE       = 3'd5,
        MODE_READ       = 3'd6,
        MODE_SPARE      = 3'd7
    } mode_t;

    // Sides of an outline, drawn one after another
    typedef enum logic [1:0] {
        SIDE_TOP    = 2'd0,
        SIDE_BOTTOM = 2'd1,
        SIDE_LEFT   = 2'd2,
        SIDE_RIGHT  = 2'd3
    } side_t;

    // Command sequencer states
    typedef enum logic [3:0] {
        ST_WIPE_GO,
        ST_WIPE,
        ST_IDLE,
        ST_DECODE,
        ST_PICK,
        ST_CLIP,
        ST_DRAW,
        ST_LOOKUP,
        ST_FETCH,
        ST_REPLY
    } seq_state_t;

    // Raster engine states
    typedef enum logic [1:0] {
        R_IDLE,
        R_SETUP,
        R_RUN
    } raster_state_t;

    // Clipped rectangle, inclusive bounds, all on screen
    typedef struct packed {
        col_t col_lo;
        col_t col_hi;
        row_t row_lo;
        row_t row_hi;
    } rect_t;

    // One memory access
    typedef struct packed {
        logic  we;
        addr_t addr;
        pix_t  data;
    } mem_req_t;

    // Requests to the dirty box unit
    typedef struct packed {
        logic grow;
        logic full;
        logic take;
    } box_ctl_t;

    // Dirty box state
    typedef struct packed {
        logic valid;
        col_t left;
        row_t top;
        col_t right;
        row_t bottom;
    } box_t;

    localparam rect_t FULL_RECT = '{
        col_lo: '0,
        col_hi: COL_W'(SCREEN_WIDTH - 1),
        row_lo: '0,
        row_hi: ROW_W'(SCREEN_HEIGHT - 1)
    };

endpackage

// ===== rtl/fbfd_ram.sv =====
module fbfd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Single port, registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ===== rtl/fbfd_raster.sv =====
module fbfd_raster (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  fbfd_pkg::rect_t      rect,
    input  fbfd_pkg::pix_t       color,
    output fbfd_pkg::mem_req_t   wr,
    output logic                 done,
    output logic                 active
);

    fbfd_pkg::raster_state_t state_reg, state_next;
    fbfd_pkg::rect_t         rect_reg;
    fbfd_pkg::pix_t          color_reg;
    fbfd_pkg::col_t          col_reg;
    fbfd_pkg::row_t          row_reg;
    fbfd_pkg::addr_t         addr_reg;
    fbfd_pkg::addr_t         line_reg;
    logic                    last_col;
    logic                    last_pix;

    assign last_col = (col_reg == rect_reg.col_hi);
    assign last_pix = last_col && (row_reg == rect_reg.row_hi);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            fbfd_pkg::R_IDLE:
            begin
                if (start)
                begin
                    state_next = fbfd_pkg::R_SETUP;
                end
            end
            fbfd_pkg::R_SETUP:
            begin
                state_next = fbfd_pkg::R_RUN;
            end
            fbfd_pkg::R_RUN:
            begin
                if (last_pix)
                begin
                    state_next = fbfd_pkg::R_IDLE;
                end
            end
            default:
            begin
                state_next = fbfd_pkg::R_IDLE;
            end
        endcase
    end

    // Outputs: one pixel written per cycle while running
    always_comb
    begin
        wr.we   = (state_reg == fbfd_pkg::R_RUN);
        wr.addr = addr_reg;
        wr.data = color_reg;
        done    = (state_reg == fbfd_pkg::R_RUN) && last_pix;
        active  = (state_reg != fbfd_pkg::R_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fbfd_pkg::R_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Raster walk: the address follows the column, the line start steps by one row
    always_ff @(posedge clk)
    begin
        case (state_reg)
            fbfd_pkg::R_IDLE:
            begin
                if (start)
                begin
                    rect_reg  <= rect;
                    color_reg <= color;
                end
            end
            fbfd_pkg::R_SETUP:
            begin
                col_reg  <= rect_reg.col_lo;
                row_reg  <= rect_reg.row_lo;
                line_reg <= fbfd_pkg::ADDR_W'(
                                fbfd_pkg::ADDR_W'(rect_reg.row_lo)
                                * fbfd_pkg::ADDR_W'(fbfd_pkg::SCREEN_WIDTH))
                            + fbfd_pkg::ADDR_W'(rect_reg.col_lo);
                addr_reg <= fbfd_pkg::ADDR_W'(
                                fbfd_pkg::ADDR_W'(rect_reg.row_lo)
                                * fbfd_pkg::ADDR_W'(fbfd_pkg::SCREEN_WIDTH))
                            + fbfd_pkg::ADDR_W'(rect_reg.col_lo);
            end
            fbfd_pkg::R_RUN:
            begin
                if (last_col)
                begin
                    col_reg  <= rect_reg.col_lo;
                    row_reg  <= row_reg + fbfd_pkg::ROW_W'(1);
                    line_reg <= line_reg + fbfd_pkg::ADDR_W'(fbfd_pkg::SCREEN_WIDTH);
                    addr_reg <= line_reg + fbfd_pkg::ADDR_W'(fbfd_pkg::SCREEN_WIDTH);
                end
                else
                begin
                    col_reg  <= col_reg + fbfd_pkg::COL_W'(1);
                    addr_reg <= addr_reg + fbfd_pkg::ADDR_W'(1);
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

// ===== rtl/fbfd_box.sv =====
module fbfd_box (
    input  logic                clk,
    input  logic                rst_n,
    input  fbfd_pkg::box_ctl_t  ctl,
    input  fbfd_pkg::rect_t     rect,
    output fbfd_pkg::box_t      box
);

    fbfd_pkg::box_t box_reg, box_next;

    // Full screen, else grow over the rect (restart if empty), else invalid
    always_comb
    begin
        box_next = box_reg;
        if (ctl.full)
        begin
            box_next.valid  = 1'b1;
            box_next.left   = fbfd_pkg::FULL_RECT.col_lo;
            box_next.top    = fbfd_pkg::FULL_RECT.row_lo;
            box_next.right  = fbfd_pkg::FULL_RECT.col_hi;
            box_next.bottom = fbfd_pkg::FULL_RECT.row_hi;
        end
        else if (ctl.grow)
        begin
            box_next.valid = 1'b1;
            if (!box_reg.valid || rect.col_lo < box_reg.left)
            begin
                box_next.left = rect.col_lo;
            end
            if (!box_reg.valid || rect.col_hi > box_reg.right)
            begin
                box_next.right = rect.col_hi;
            end
            if (!box_reg.valid || rect.row_lo < box_reg.top)
            begin
                box_next.top = rect.row_lo;
            end
            if (!box_reg.valid || rect.row_hi > box_reg.bottom)
            begin
                box_next.bottom = rect.row_hi;
            end
        end
        else if (ctl.take)
        begin
            box_next.valid = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_reg.valid  <= 1'b1;
            box_reg.left   <= fbfd_pkg::FULL_RECT.col_lo;
            box_reg.top    <= fbfd_pkg::FULL_RECT.row_lo;
            box_reg.right  <= fbfd_pkg::FULL_RECT.col_hi;
            box_reg.bottom <= fbfd_pkg::FULL_RECT.row_hi;
        end
        else
        begin
            box_reg <= box_next;
        end
    end

    assign box = box_reg;

endmodule

// ===== rtl/framebuffer_fill_with_dirty_box_core.sv =====
// Channel  Direction  Signals                          Contents
// s_axis   in         tvalid tready tdata[79:0] tuser  one drawing command
// m_axis   out        tvalid tready tdata[47:0]        one result per command
//
// After reset the pixel memory is swept to zero, one pixel a cycle, and input is
// refused until the sweep is done. A command is taken only when the one before has
// finished, and fills and clears are paced by the single memory write port.
// An outline draws its four sides one after the other. The result sits in an output
// register, so a stalled m_axis only holds up the command after the waiting result.
module framebuffer_fill_with_dirty_box_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // x_pos[15:0], y_pos[31:16], rect_width[47:32], rect_height[63:48], color[79:64]
    input  logic [79:0] s_axis_tdata,
    // mode[2:0]
    input  logic [2:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // pixel_value[15:0], dirty_any[16], dirty_left[24:17], dirty_top[31:25],
    // dirty_right[39:32], dirty_bottom[46:40], zero[47]
    output logic [47:0] m_axis_tdata
);

    fbfd_pkg::seq_state_t state_reg, state_next;

    // Command held for its whole duration
    fbfd_pkg::mode_t                      mode_reg;
    logic signed [fbfd_pkg::FIELD_W-1:0]  x_reg;
    logic signed [fbfd_pkg::FIELD_W-1:0]  y_reg;
    logic signed [fbfd_pkg::FIELD_W-1:0]  w_reg;
    logic signed [fbfd_pkg::FIELD_W-1:0]  h_reg;
    fbfd_pkg::pix_t                       color_reg;
    fbfd_pkg::side_t                      side_reg;

    // Unclipped rectangle of the current fill
    fbfd_pkg::coord_t sx_reg, sy_reg, sw_reg, sh_reg;
    fbfd_pkg::coord_t sx_next, sy_next, sw_next, sh_next;

    fbfd_pkg::pix_t   pix_reg;
    logic             out_valid_reg;
    logic [47:0]      out_data_reg;

    // Wide copies of the command fields
    fbfd_pkg::coord_t cx, cy, cw, ch;
    fbfd_pkg::coord_t one_c, width_c, height_c;

    // Clipping
    fbfd_pkg::coord_t x0, y0, x1, y1;
    logic             clip_empty;
    fbfd_pkg::rect_t  clip_rect;

    logic             on_screen;
    logic             outline_ok;
    logic             more_sides;
    logic             out_load;

    // Raster, box and memory connections
    logic                 raster_start;
    fbfd_pkg::rect_t      raster_rect;
    fbfd_pkg::pix_t       raster_color;
    fbfd_pkg::mem_req_t   raster_wr;
    logic                 raster_done;
    logic                 raster_active;
    fbfd_pkg::box_ctl_t   box_ctl;
    fbfd_pkg::box_t       box;
    fbfd_pkg::mem_req_t   mem_req;
    fbfd_pkg::pix_t       mem_rdata;
    fbfd_pkg::addr_t      read_addr;

    assign cx       = fbfd_pkg::coord_t'(x_reg);
    assign cy       = fbfd_pkg::coord_t'(y_reg);
    assign cw       = fbfd_pkg::coord_t'(w_reg);
    assign ch       = fbfd_pkg::coord_t'(h_reg);
    assign one_c    = fbfd_pkg::coord_t'(1);
    assign width_c  = fbfd_pkg::coord_t'(fbfd_pkg::SCREEN_WIDTH);
    assign height_c = fbfd_pkg::coord_t'(fbfd_pkg::SCREEN_HEIGHT);

    assign on_screen  = (cx >= 0) && (cy >= 0) && (cx < width_c) && (cy < height_c);
    assign outline_ok = (cw > 0) && (ch > 0);
    assign more_sides = (mode_reg == fbfd_pkg::MODE_OUTLINE)
                        && (side_reg != fbfd_pkg::SIDE_RIGHT);
    assign out_load   = !out_valid_reg || m_axis_tready;

    // Pick the rectangle to fill: the whole command or one side of an outline
    always_comb
    begin
        sx_next = cx;
        sy_next = cy;
        sw_next = cw;
        sh_next = ch;
        if (mode_reg == fbfd_pkg::MODE_PIXEL)
        begin
            sw_next = one_c;
            sh_next = one_c;
        end
        else if (mode_reg == fbfd_pkg::MODE_OUTLINE)
        begin
            case (side_reg)
                fbfd_pkg::SIDE_TOP:
                begin
                    sh_next = one_c;
                end
                fbfd_pkg::SIDE_BOTTOM:
                begin
                    sy_next = cy + ch - one_c;
                    sh_next = one_c;
                end
                fbfd_pkg::SIDE_LEFT:
                begin
                    sw_next = one_c;
                end
                fbfd_pkg::SIDE_RIGHT:
                begin
                    sx_next = cx + cw - one_c;
                    sw_next = one_c;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Clip the picked rectangle to the screen
    always_comb
    begin
        x0 = (sx_reg < 0) ? '0 : sx_reg;
        y0 = (sy_reg < 0) ? '0 : sy_reg;
        x1 = sx_reg + sw_reg;
        y1 = sy_reg + sh_reg;
        if (x1 > width_c)
        begin
            x1 = width_c;
        end
        if (y1 > height_c)
        begin
            y1 = height_c;
        end
        clip_empty       = (x0 >= x1) || (y0 >= y1);
        clip_rect.col_lo = x0[fbfd_pkg::COL_W-1:0];
        clip_rect.col_hi = fbfd_pkg::COL_W'(x1 - one_c);
        clip_rect.row_lo = y0[fbfd_pkg::ROW_W-1:0];
        clip_rect.row_hi = fbfd_pkg::ROW_W'(y1 - one_c);
    end

    assign read_addr = fbfd_pkg::ADDR_W'(
                           fbfd_pkg::ADDR_W'(y_reg[fbfd_pkg::ROW_W-1:0])
                           * fbfd_pkg::ADDR_W'(fbfd_pkg::SCREEN_WIDTH))
                       + fbfd_pkg::ADDR_W'(x_reg[fbfd_pkg::COL_W-1:0]);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            fbfd_pkg::ST_WIPE_GO:
            begin
                state_next = fbfd_pkg::ST_WIPE;
            end
            fbfd_pkg::ST_WIPE:
            begin
                if (raster_done)
                begin
                    state_next = fbfd_pkg::ST_IDLE;
                end
            end
            fbfd_pkg::ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    state_next = fbfd_pkg::ST_DECODE;
                end
            end
            fbfd_pkg::ST_DECODE:
            begin
                case (mode_reg)
                    fbfd_pkg::MODE_PIXEL, fbfd_pkg::MODE_FILL:
                    begin
                        state_next = fbfd_pkg::ST_PICK;
                    end
                    fbfd_pkg::MODE_OUTLINE:
                    begin
                        state_next = outline_ok ? fbfd_pkg::ST_PICK : fbfd_pkg::ST_REPLY;
                    end
                    fbfd_pkg::MODE_CLEAR:
                    begin
                        state_next = fbfd_pkg::ST_DRAW;
                    end
                    fbfd_pkg::MODE_READ:
                    begin
                        state_next = on_screen ? fbfd_pkg::ST_LOOKUP : fbfd_pkg::ST_REPLY;
                    end
                    default:
                    begin
                        state_next = fbfd_pkg::ST_REPLY;
                    end
                endcase
            end
            fbfd_pkg::ST_PICK:
            begin
                state_next = fbfd_pkg::ST_CLIP;
            end
            fbfd_pkg::ST_CLIP:
            begin
                if (!clip_empty)
                begin
                    state_next = fbfd_pkg::ST_DRAW;
                end
                else if (more_sides)
                begin
                    state_next = fbfd_pkg::ST_PICK;
                end
                else
                begin
                    state_next = fbfd_pkg::ST_REPLY;
                end
            end
            fbfd_pkg::ST_DRAW:
            begin
                if (raster_done)
                begin
                    state_next = more_sides ? fbfd_pkg::ST_PICK : fbfd_pkg::ST_REPLY;
                end
            end
            fbfd_pkg::ST_LOOKUP:
            begin
                state_next = fbfd_pkg::ST_FETCH;
            end
            fbfd_pkg::ST_FETCH:
            begin
                state_next = fbfd_pkg::ST_REPLY;
            end
            fbfd_pkg::ST_REPLY:
            begin
                if (out_load)
                begin
                    state_next = fbfd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = fbfd_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer
    always_comb
    begin
        s_axis_tready = 1'b0;
        raster_start  = 1'b0;
        raster_rect   = fbfd_pkg::FULL_RECT;
        raster_color  = color_reg;
        box_ctl       = '0;
        mem_req       = raster_wr;
        case (state_reg)
            fbfd_pkg::ST_WIPE_GO:
            begin
                raster_start = 1'b1;
                raster_color = '0;
            end
            fbfd_pkg::ST_IDLE:
            begin
                s_axis_tready = 1'b1;
            end
            fbfd_pkg::ST_DECODE:
            begin
                if (mode_reg == fbfd_pkg::MODE_CLEAR)
                begin
                    raster_start = 1'b1;
                    box_ctl.full = 1'b1;
                end
                else if (mode_reg == fbfd_pkg::MODE_INVALIDATE)
                begin
                    box_ctl.full = 1'b1;
                end
            end
            fbfd_pkg::ST_CLIP:
            begin
                raster_rect = clip_rect;
                if (!clip_empty)
                begin
                    raster_start = 1'b1;
                    box_ctl.grow = 1'b1;
                end
            end
            fbfd_pkg::ST_LOOKUP:
            begin
                mem_req.we   = 1'b0;
                mem_req.addr = read_addr;
            end
            fbfd_pkg::ST_REPLY:
            begin
                box_ctl.take = out_load && (mode_reg == fbfd_pkg::MODE_TAKE);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fbfd_pkg::ST_WIPE_GO;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == fbfd_pkg::ST_REPLY && out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Command capture, side stepping and result assembly
    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            mode_reg  <= fbfd_pkg::mode_t'(s_axis_tuser);
            x_reg     <= s_axis_tdata[15:0];
            y_reg     <= s_axis_tdata[31:16];
            w_reg     <= s_axis_tdata[47:32];
            h_reg     <= s_axis_tdata[63:48];
            color_reg <= s_axis_tdata[79:64];
        end
        if (state_reg == fbfd_pkg::ST_DECODE)
        begin
            side_reg <= fbfd_pkg::SIDE_TOP;
            pix_reg  <= '0;
        end
        if (state_reg == fbfd_pkg::ST_PICK)
        begin
            sx_reg <= sx_next;
            sy_reg <= sy_next;
            sw_reg <= sw_next;
            sh_reg <= sh_next;
        end
        if ((state_reg == fbfd_pkg::ST_CLIP && clip_empty)
            || (state_reg == fbfd_pkg::ST_DRAW && raster_done))
        begin
            side_reg <= fbfd_pkg::side_t'(side_reg + 2'd1);
        end
        if (state_reg == fbfd_pkg::ST_FETCH)
        begin
            pix_reg <= mem_rdata;
        end
        if (state_reg == fbfd_pkg::ST_REPLY && out_load)
        begin
            out_data_reg <= {1'b0,
                             fbfd_pkg::OUT_ROW_W'(box.bottom),
                             fbfd_pkg::OUT_COL_W'(box.right),
                             fbfd_pkg::OUT_ROW_W'(box.top),
                             fbfd_pkg::OUT_COL_W'(box.left),
                             box.valid,
                             pix_reg};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    fbfd_raster u_raster (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (raster_start),
        .rect   (raster_rect),
        .color  (raster_color),
        .wr     (raster_wr),
        .done   (raster_done),
        .active (raster_active)
    );

    fbfd_box u_box (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (box_ctl),
        .rect  (clip_rect),
        .box   (box)
    );

    fbfd_ram #(
        .WIDTH (fbfd_pkg::PIX_W),
        .DEPTH (fbfd_pkg::PIX_COUNT)
    ) u_frame_ram (
        .clk   (clk),
        .we    (mem_req.we),
        .addr  (mem_req.addr),
        .wdata (mem_req.data),
        .rdata (mem_rdata)
    );

    // No command is taken while the raster engine still writes
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> !raster_active)
        else $error("input ready while raster engine active");

    // A pixel read never shares its cycle with a write
    a_read_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == fbfd_pkg::ST_LOOKUP) |-> !mem_req.we)
        else $error("memory write during pixel lookup");

    // A valid dirty box is never inverted
    a_box_order: assert property (@(posedge clk) disable iff (!rst_n)
        box.valid |-> (box.left <= box.right) && (box.top <= box.bottom))
        else $error("dirty box bounds inverted");

    // The raster engine only finishes inside a drawing state
    a_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        raster_done |-> (state_reg == fbfd_pkg::ST_DRAW) || (state_reg == fbfd_pkg::ST_WIPE))
        else $error("raster completion outside a drawing state");

endmodule
